/* sv/lll_pkg.sv */
// Shared types, constants and helpers for the pooled linked list engine.
// No dependencies; used by every other file of the block.
package lll_pkg;

	localparam int POOL_NODES = 15;
	localparam int IDX_BITS   = 4;
	localparam int DATA_BITS  = 32;
	localparam int MEM_DEPTH  = POOL_NODES + 1;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_EMPTY    = 2'd2,
		STAT_BAD_PRED = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_CHK,
		S_INS_RDT,
		S_INS_RDP,
		S_INS_WRP,
		S_DEL_CHK,
		S_DEL_RDH,
		S_DEL_RDP,
		S_DEL_RDT,
		S_DEL_FREE,
		S_SRCH_INIT,
		S_SRCH_CMP,
		S_RD_ISS,
		S_RD_CAP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                 en_data;
		logic                 en_link;
		logic [IDX_BITS-1:0]  addr;
		logic [DATA_BITS-1:0] data;
		logic [IDX_BITS-1:0]  link;
	} ram_wr_t;

	typedef struct packed {
		logic [DATA_BITS-1:0] data;
		logic [IDX_BITS-1:0]  link;
	} ram_rd_t;

	typedef struct packed {
		logic ge;
		logic eq;
	} cmp_t;

	function automatic logic node_valid(input logic [IDX_BITS-1:0] i);
		return (i != '0) && ({1'b0, i} <= (IDX_BITS + 1)'(POOL_NODES));
	endfunction

	function automatic logic [DATA_BITS-1:0] data_reset(input logic [IDX_BITS-1:0] i);
		if (i == '0 || i == IDX_BITS'(POOL_NODES)) begin
			return '0;
		end
		return '1;
	endfunction

	function automatic logic [IDX_BITS-1:0] link_reset(input logic [IDX_BITS-1:0] i);
		if (i == '0 || i == IDX_BITS'(POOL_NODES)) begin
			return '0;
		end
		return i + IDX_BITS'(1);
	endfunction

endpackage

/* sv/lll_node_ram.sv */
// Node pool storage: data words and next links with one registered read port.
// Per-entry valid bits stand in for the reset image. Depends on lll_pkg.
module lll_node_ram (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [lll_pkg::IDX_BITS-1:0]  rd_addr,
	input  lll_pkg::ram_wr_t              wr,
	output lll_pkg::ram_rd_t              rd
);

	logic [lll_pkg::DATA_BITS-1:0] data_mem [lll_pkg::MEM_DEPTH];
	logic [lll_pkg::IDX_BITS-1:0]  link_mem [lll_pkg::MEM_DEPTH];
	logic [lll_pkg::MEM_DEPTH-1:0] data_vld_q;
	logic [lll_pkg::MEM_DEPTH-1:0] link_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_vld_q <= '0;
			link_vld_q <= '0;
		end else begin
			if (wr.en_data) begin
				data_vld_q[wr.addr] <= 1'b1;
			end
			if (wr.en_link) begin
				link_vld_q[wr.addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en_data) begin
			data_mem[wr.addr] <= wr.data;
		end
		if (wr.en_link) begin
			link_mem[wr.addr] <= wr.link;
		end
	end

	always_ff @(posedge clk) begin
		rd.data <= data_vld_q[rd_addr] ? data_mem[rd_addr] : lll_pkg::data_reset(rd_addr);
		rd.link <= link_vld_q[rd_addr] ? link_mem[rd_addr] : lll_pkg::link_reset(rd_addr);
	end

endmodule

/* sv/lll_cmp.sv */
// Shared signed compare unit used by the search walk.
// Depends on lll_pkg.
module lll_cmp (
	input  logic signed [lll_pkg::DATA_BITS-1:0] a,
	input  logic signed [lll_pkg::DATA_BITS-1:0] b,
	output lll_pkg::cmp_t                        res
);

	assign res.ge = (a >= b);
	assign res.eq = (a == b);

endmodule

/* sv/pooled_linked_list_engine_core.sv */
// Top level of the pooled linked list engine: sequencer, list registers and results.
// Depends on lll_pkg, lll_node_ram and lll_cmp.
//
// One command is taken when start is high and busy is low; busy then stays high through
// the cycle that shows the result. The result is on the outputs for exactly one cycle,
// marked by done, and must be captured then: the receiver cannot stall the block.
// The single node memory port paces every command: each link followed costs one registered
// read, and the walk compares one node per cycle in the shared compare unit, at most fifteen
// nodes for the fifteen-node pool. The reset image of the pool is held by per-entry valid
// bits, so no clearing pass follows reset.
module pooled_linked_list_engine_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            op,
	input  logic [lll_pkg::IDX_BITS-1:0]          node_index,
	input  logic signed [31:0]                    item_value,
	output logic                                  done,
	output logic [1:0]                            status,
	output logic [lll_pkg::IDX_BITS-1:0]          slot_index,
	output logic                                  found,
	output logic [lll_pkg::IDX_BITS-1:0]          pred_out,
	output logic signed [31:0]                    data_out,
	output logic [lll_pkg::IDX_BITS-1:0]          next_out,
	output logic [lll_pkg::IDX_BITS-1:0]          head_out,
	output logic [lll_pkg::IDX_BITS-1:0]          free_out
);

	lll_pkg::state_t                state_q, state_d;
	lll_pkg::op_t                   op_in;
	logic [lll_pkg::IDX_BITS-1:0]   idx_q, head_q, free_q, t_q, cur_q, pred_q, steps_q;
	logic [lll_pkg::IDX_BITS-1:0]   slot_q, next_q;
	logic [lll_pkg::DATA_BITS-1:0]  item_q, data_q;
	lll_pkg::status_t               status_q;
	logic                           found_q;
	logic [lll_pkg::IDX_BITS-1:0]   rd_addr;
	lll_pkg::ram_wr_t               wr;
	lll_pkg::ram_rd_t               rd;
	lll_pkg::cmp_t                  cmp;
	logic                           accept;
	logic                           walk_last;

	assign op_in     = lll_pkg::op_t'(op);
	assign accept    = start && (state_q == lll_pkg::S_IDLE);
	assign walk_last = (steps_q == lll_pkg::IDX_BITS'(lll_pkg::POOL_NODES - 1))
		|| !lll_pkg::node_valid(rd.link);

	lll_node_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.wr      (wr),
		.rd      (rd)
	);

	lll_cmp u_cmp (
		.a   (rd.data),
		.b   (item_q),
		.res (cmp)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lll_pkg::S_IDLE: begin
				if (start) begin
					unique case (op_in)
						lll_pkg::OP_INSERT: state_d = lll_pkg::S_INS_CHK;
						lll_pkg::OP_DELETE: state_d = lll_pkg::S_DEL_CHK;
						lll_pkg::OP_SEARCH: state_d = lll_pkg::S_SRCH_INIT;
						lll_pkg::OP_READ:   state_d = lll_pkg::S_RD_ISS;
						default:            state_d = lll_pkg::S_IDLE;
					endcase
				end
			end
			lll_pkg::S_INS_CHK: begin
				if ((idx_q != '0 && !lll_pkg::node_valid(idx_q)) || free_q == '0) begin
					state_d = lll_pkg::S_DONE;
				end else begin
					state_d = lll_pkg::S_INS_RDT;
				end
			end
			lll_pkg::S_INS_RDT: state_d = (idx_q == '0) ? lll_pkg::S_DONE : lll_pkg::S_INS_RDP;
			lll_pkg::S_INS_RDP: state_d = lll_pkg::S_INS_WRP;
			lll_pkg::S_INS_WRP: state_d = lll_pkg::S_DONE;
			lll_pkg::S_DEL_CHK: begin
				priority if (head_q == '0) begin
					state_d = lll_pkg::S_DONE;
				end else if (idx_q == '0) begin
					state_d = lll_pkg::S_DEL_RDH;
				end else if (!lll_pkg::node_valid(idx_q)) begin
					state_d = lll_pkg::S_DONE;
				end else begin
					state_d = lll_pkg::S_DEL_RDP;
				end
			end
			lll_pkg::S_DEL_RDH: state_d = lll_pkg::S_DONE;
			lll_pkg::S_DEL_RDP: state_d = (rd.link == '0) ? lll_pkg::S_DONE : lll_pkg::S_DEL_RDT;
			lll_pkg::S_DEL_RDT: state_d = lll_pkg::S_DEL_FREE;
			lll_pkg::S_DEL_FREE: state_d = lll_pkg::S_DONE;
			lll_pkg::S_SRCH_INIT: begin
				state_d = lll_pkg::node_valid(head_q) ? lll_pkg::S_SRCH_CMP : lll_pkg::S_DONE;
			end
			lll_pkg::S_SRCH_CMP: begin
				if (cmp.ge || walk_last) begin
					state_d = lll_pkg::S_DONE;
				end
			end
			lll_pkg::S_RD_ISS: begin
				state_d = lll_pkg::node_valid(idx_q) ? lll_pkg::S_RD_CAP : lll_pkg::S_DONE;
			end
			lll_pkg::S_RD_CAP: state_d = lll_pkg::S_DONE;
			lll_pkg::S_DONE:   state_d = lll_pkg::S_IDLE;
			default:           state_d = lll_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		rd_addr = '0;
		wr      = '0;
		unique case (state_q)
			lll_pkg::S_INS_CHK: rd_addr = free_q;
			lll_pkg::S_INS_RDT: begin
				rd_addr = idx_q;
				if (idx_q == '0) begin
					wr.en_data = 1'b1;
					wr.en_link = 1'b1;
					wr.addr    = t_q;
					wr.data    = item_q;
					wr.link    = head_q;
				end
			end
			lll_pkg::S_INS_RDP: begin
				wr.en_data = 1'b1;
				wr.en_link = 1'b1;
				wr.addr    = t_q;
				wr.data    = item_q;
				wr.link    = rd.link;
			end
			lll_pkg::S_INS_WRP: begin
				wr.en_link = 1'b1;
				wr.addr    = idx_q;
				wr.link    = t_q;
			end
			lll_pkg::S_DEL_CHK: rd_addr = (idx_q == '0) ? head_q : idx_q;
			lll_pkg::S_DEL_RDH, lll_pkg::S_DEL_FREE: begin
				wr.en_data = lll_pkg::node_valid(t_q);
				wr.en_link = lll_pkg::node_valid(t_q);
				wr.addr    = t_q;
				wr.data    = '1;
				wr.link    = free_q;
			end
			lll_pkg::S_DEL_RDP: rd_addr = rd.link;
			lll_pkg::S_DEL_RDT: begin
				wr.en_link = 1'b1;
				wr.addr    = idx_q;
				wr.link    = lll_pkg::node_valid(t_q) ? rd.link : '0;
			end
			lll_pkg::S_SRCH_INIT: rd_addr = head_q;
			lll_pkg::S_SRCH_CMP:  rd_addr = rd.link;
			lll_pkg::S_RD_ISS:    rd_addr = idx_q;
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lll_pkg::S_IDLE;
			head_q  <= '0;
			free_q  <= lll_pkg::IDX_BITS'(1);
		end else begin
			state_q <= state_d;
			unique case (state_q)
				lll_pkg::S_INS_RDT: begin
					free_q <= lll_pkg::node_valid(t_q) ? rd.link : '0;
					if (idx_q == '0) begin
						head_q <= t_q;
					end
				end
				lll_pkg::S_DEL_RDH: begin
					head_q <= lll_pkg::node_valid(t_q) ? rd.link : '0;
					if (lll_pkg::node_valid(t_q)) begin
						free_q <= t_q;
					end
				end
				lll_pkg::S_DEL_FREE: begin
					if (lll_pkg::node_valid(t_q)) begin
						free_q <= t_q;
					end
				end
				default: begin
					head_q <= head_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q    <= node_index;
			item_q   <= item_value;
			status_q <= lll_pkg::STAT_OK;
			slot_q   <= '0;
			found_q  <= 1'b0;
			pred_q   <= '0;
			data_q   <= '0;
			next_q   <= '0;
		end
		unique case (state_q)
			lll_pkg::S_INS_CHK: begin
				priority if (idx_q != '0 && !lll_pkg::node_valid(idx_q)) begin
					status_q <= lll_pkg::STAT_BAD_PRED;
				end else if (free_q == '0) begin
					status_q <= lll_pkg::STAT_FULL;
				end else begin
					t_q <= free_q;
				end
			end
			lll_pkg::S_INS_RDT: slot_q <= t_q;
			lll_pkg::S_DEL_CHK: begin
				priority if (head_q == '0) begin
					status_q <= lll_pkg::STAT_EMPTY;
				end else if (idx_q == '0) begin
					t_q <= head_q;
				end else if (!lll_pkg::node_valid(idx_q)) begin
					status_q <= lll_pkg::STAT_BAD_PRED;
				end
			end
			lll_pkg::S_DEL_RDH:  slot_q <= t_q;
			lll_pkg::S_DEL_RDP: begin
				if (rd.link == '0) begin
					status_q <= lll_pkg::STAT_BAD_PRED;
				end else begin
					t_q <= rd.link;
				end
			end
			lll_pkg::S_DEL_FREE: slot_q <= t_q;
			lll_pkg::S_SRCH_INIT: begin
				cur_q   <= head_q;
				steps_q <= '0;
			end
			lll_pkg::S_SRCH_CMP: begin
				if (cmp.ge) begin
					found_q <= cmp.eq;
				end else begin
					pred_q  <= cur_q;
					cur_q   <= rd.link;
					steps_q <= steps_q + lll_pkg::IDX_BITS'(1);
				end
			end
			lll_pkg::S_RD_CAP: begin
				slot_q <= idx_q;
				data_q <= rd.data;
				next_q <= rd.link;
			end
			default: begin
				t_q <= t_q;
			end
		endcase
	end

	assign busy       = (state_q != lll_pkg::S_IDLE);
	assign done       = (state_q == lll_pkg::S_DONE);
	assign status     = status_q;
	assign slot_index = slot_q;
	assign found      = found_q;
	assign pred_out   = pred_q;
	assign data_out   = data_q;
	assign next_out   = next_q;
	assign head_out   = head_q;
	assign free_out   = free_q;

	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_full_no_free: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == lll_pkg::STAT_FULL) |-> (free_out == '0))
		else $error("pool full reported with a free node");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (status == lll_pkg::STAT_OK && slot_index == '0))
		else $error("search result carries status or slot");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for pooled_linked_list_engine_core: directed and random list commands,
// with results predicted from a behavioral copy of the node pool and free list.
// Depends on lll_pkg and the engine RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		lll_pkg::op_t                  op;
		logic [lll_pkg::IDX_BITS-1:0]  idx;
		logic signed [31:0]            val;
		int                            gap;
	} cmd_t;

	typedef struct packed {
		lll_pkg::status_t              status;
		logic [lll_pkg::IDX_BITS-1:0]  slot;
		logic                          found;
		logic [lll_pkg::IDX_BITS-1:0]  pred;
		logic [31:0]                   data;
		logic [lll_pkg::IDX_BITS-1:0]  nxt;
		logic [lll_pkg::IDX_BITS-1:0]  head;
		logic [lll_pkg::IDX_BITS-1:0]  free_idx;
	} list_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic [1:0]                    op = '0;
	logic [lll_pkg::IDX_BITS-1:0]  node_index = '0;
	logic signed [31:0]            item_value = '0;
	logic                          busy;
	logic                          done;
	logic [1:0]                    status;
	logic [lll_pkg::IDX_BITS-1:0]  slot_index;
	logic                          found;
	logic [lll_pkg::IDX_BITS-1:0]  pred_out;
	logic signed [31:0]            data_out;
	logic [lll_pkg::IDX_BITS-1:0]  next_out;
	logic [lll_pkg::IDX_BITS-1:0]  head_out;
	logic [lll_pkg::IDX_BITS-1:0]  free_out;

	logic signed [31:0]            pool_data [lll_pkg::MEM_DEPTH];
	logic [lll_pkg::IDX_BITS-1:0]  pool_link [lll_pkg::MEM_DEPTH];
	logic [lll_pkg::IDX_BITS-1:0]  list_head;
	logic [lll_pkg::IDX_BITS-1:0]  free_top;

	cmd_t                 cmd_q [$];
	list_result_t         want_q [$];
	cmd_t                 live_cmd;
	int                   wait_cnt = 0;
	int                   err_cnt = 0;

	pooled_linked_list_engine_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.node_index (node_index),
		.item_value (item_value),
		.done       (done),
		.status     (status),
		.slot_index (slot_index),
		.found      (found),
		.pred_out   (pred_out),
		.data_out   (data_out),
		.next_out   (next_out),
		.head_out   (head_out),
		.free_out   (free_out)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: errors");
		$finish;
	end

	function automatic list_result_t list_apply(cmd_t c);
		list_result_t                  r;
		logic [lll_pkg::IDX_BITS-1:0]  t;
		logic [lll_pkg::IDX_BITS-1:0]  cur;
		int                            steps;
		r = '0;
		t = '0;
		unique case (c.op)
			lll_pkg::OP_INSERT: begin
				if (free_top == 0) begin
					r.status = lll_pkg::STAT_FULL;
				end else begin
					t = free_top;
					free_top = pool_link[t];
					pool_data[t] = c.val;
					if (c.idx == 0) begin
						pool_link[t] = list_head;
						list_head = t;
					end else begin
						pool_link[t] = pool_link[c.idx];
						pool_link[c.idx] = t;
					end
					r.slot = t;
				end
			end
			lll_pkg::OP_DELETE: begin
				if (list_head == 0) begin
					r.status = lll_pkg::STAT_EMPTY;
				end else if (c.idx == 0) begin
					t = list_head;
					list_head = pool_link[t];
				end else if (pool_link[c.idx] == 0) begin
					r.status = lll_pkg::STAT_BAD_PRED;
				end else begin
					t = pool_link[c.idx];
					pool_link[c.idx] = pool_link[t];
				end
				// return the unlinked node to the front of the free chain
				if (t != 0) begin
					pool_link[t] = free_top;
					pool_data[t] = '1;
					free_top = t;
					r.slot = t;
				end
			end
			lll_pkg::OP_SEARCH: begin
				cur = list_head;
				steps = 0;
				while (cur != 0 && steps < lll_pkg::POOL_NODES) begin
					if ($signed(pool_data[cur]) >= $signed(c.val)) begin
						r.found = (pool_data[cur] == c.val);
						break;
					end
					r.pred = cur;
					cur = pool_link[cur];
					steps++;
				end
			end
			default: begin
				if (c.idx != 0) begin
					r.slot = c.idx;
					r.data = pool_data[c.idx];
					r.nxt = pool_link[c.idx];
				end
			end
		endcase
		r.head = list_head;
		r.free_idx = free_top;
		return r;
	endfunction

	task automatic queue_cmd(lll_pkg::op_t o, logic [lll_pkg::IDX_BITS-1:0] i,
		logic signed [31:0] v);
		cmd_t c;
		c.op = o;
		c.idx = i;
		c.val = v;
		c.gap = $urandom_range(0, 7);
		cmd_q.push_back(c);
	endtask

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			err_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive
		bit idle_now;
		if (!arst_n) begin
			start <= 1'b0;
			op <= lll_pkg::OP_INSERT;
			node_index <= '0;
			item_value <= '0;
			wait_cnt = 0;
		end else begin
			idle_now = !start;
			if (start && !busy) begin
				want_q.push_back(list_apply(live_cmd));
				idle_now = 1'b1;
			end
			if (idle_now) begin
				if (cmd_q.size() != 0 && wait_cnt >= cmd_q[0].gap) begin
					live_cmd = cmd_q.pop_front();
					op <= live_cmd.op;
					node_index <= live_cmd.idx;
					item_value <= live_cmd.val;
					start <= 1'b1;
					wait_cnt = 0;
				end else begin
					start <= 1'b0;
					if (cmd_q.size() != 0) begin
						wait_cnt++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin : watch
		list_result_t w;
		if (arst_n && done) begin
			if (want_q.size() == 0) begin
				$error("result with no item pending");
				err_cnt++;
			end else begin
				w = want_q.pop_front();
				check_field("status", w.status, status);
				check_field("slot_index", w.slot, slot_index);
				check_field("found", w.found, found);
				check_field("pred_out", w.pred, pred_out);
				check_field("data_out", w.data, data_out);
				check_field("next_out", w.nxt, next_out);
				check_field("head_out", w.head, head_out);
				check_field("free_out", w.free_idx, free_out);
			end
		end
	end

	initial begin : stim
		cmd_t                          c;
		int                            n;
		int                            k;
		int                            roll;
		int                            ins_pct;
		bit                            gap_on;
		logic [lll_pkg::IDX_BITS-1:0]  cur;
		logic [lll_pkg::IDX_BITS-1:0]  p;
		logic signed [31:0]            v;
		logic [lll_pkg::IDX_BITS-1:0]  members [$];

		for (k = 0; k < lll_pkg::MEM_DEPTH; k++) begin
			pool_data[k] = (k == 0 || k == lll_pkg::POOL_NODES) ? 32'sd0 : -32'sd1;
			pool_link[k] = (k == 0 || k == lll_pkg::POOL_NODES) ? '0
				: lll_pkg::IDX_BITS'(k + 1);
		end
		list_head = '0;
		free_top = lll_pkg::IDX_BITS'(1);
		ins_pct = 45;
		gap_on = 1'b1;

		queue_cmd(lll_pkg::OP_READ, 0, 0);
		queue_cmd(lll_pkg::OP_READ, 15, 0);
		queue_cmd(lll_pkg::OP_SEARCH, 0, 5);
		queue_cmd(lll_pkg::OP_DELETE, 0, 0);
		queue_cmd(lll_pkg::OP_INSERT, 0, 32'sh8000_0000);
		for (k = 2; k <= 14; k++) begin
			queue_cmd(lll_pkg::OP_INSERT, lll_pkg::IDX_BITS'(k - 1), (k - 8) * 1000);
		end
		queue_cmd(lll_pkg::OP_INSERT, 14, 32'sh7fff_ffff);
		queue_cmd(lll_pkg::OP_INSERT, 0, 1);
		queue_cmd(lll_pkg::OP_SEARCH, 0, 32'sh7fff_ffff);
		queue_cmd(lll_pkg::OP_SEARCH, 0, 32'sh8000_0000);
		queue_cmd(lll_pkg::OP_DELETE, 15, 0);
		queue_cmd(lll_pkg::OP_DELETE, 0, 0);
		queue_cmd(lll_pkg::OP_DELETE, 7, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (n = 0; n < 900; n++) begin
			// hold until every queued item is accepted so the shadow list is current
			do @(negedge clk); while (cmd_q.size() != 0 || start);

			if (n % 60 == 0) begin
				ins_pct = 25 + 20 * $urandom_range(0, 2);
				gap_on = ($urandom_range(0, 3) != 0);
			end

			members.delete();
			cur = list_head;
			for (k = 0; k < lll_pkg::POOL_NODES && cur != 0; k++) begin
				members.push_back(cur);
				cur = pool_link[cur];
			end

			roll = $urandom_range(0, 99);
			if (roll < 40) begin
				v = $urandom_range(0, 40) - 20;
			end else if (roll < 50) begin
				v = $urandom_range(0, 1) ? 32'sh7fff_ffff - $urandom_range(0, 2)
					: 32'sh8000_0000 + $urandom_range(0, 2);
			end else begin
				v = $urandom;
			end

			c.gap = gap_on ? $urandom_range(0, 7) : 0;
			c.val = $urandom;
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				c.op = lll_pkg::op_t'($urandom_range(0, 3));
				c.idx = lll_pkg::IDX_BITS'($urandom_range(0, 15));
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < ins_pct) begin
					c.op = lll_pkg::OP_INSERT;
					c.val = v;
					roll = $urandom_range(0, 99);
					if (roll < 60) begin
						// keep the chain in ascending order
						p = '0;
						cur = list_head;
						for (k = 0; k < lll_pkg::POOL_NODES && cur != 0; k++) begin
							if ($signed(pool_data[cur]) >= v) begin
								break;
							end
							p = cur;
							cur = pool_link[cur];
						end
						c.idx = p;
					end else if (roll < 85 || members.size() == 0) begin
						c.idx = '0;
					end else begin
						c.idx = members[$urandom_range(0, members.size() - 1)];
					end
				end else if (roll < 70) begin
					c.op = lll_pkg::OP_DELETE;
					if (members.size() == 0 || $urandom_range(0, 3) == 0) begin
						c.idx = '0;
					end else begin
						c.idx = members[$urandom_range(0, members.size() - 1)];
					end
				end else if (roll < 90) begin
					c.op = lll_pkg::OP_SEARCH;
					c.idx = lll_pkg::IDX_BITS'($urandom_range(0, 15));
					if (members.size() != 0 && $urandom_range(0, 1) == 1) begin
						c.val = pool_data[members[$urandom_range(0, members.size() - 1)]];
					end else begin
						c.val = v;
					end
				end else begin
					c.op = lll_pkg::OP_READ;
					c.idx = lll_pkg::IDX_BITS'($urandom_range(0, 15));
				end
			end
			cmd_q.push_back(c);
		end

		do @(negedge clk); while (cmd_q.size() != 0 || start || want_q.size() != 0);
		repeat (30) @(posedge clk);

		if (err_cnt == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
